@@ design/selective_repeat_sender_window_assert.svh @@
// Assertion helpers for the sender window checker.
// Both expect clk and rst_n in the scope where they are used.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH

// Same-cycle implication.
`define SRSW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srsw check failed");

// Next-cycle implication.
`define SRSW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srsw check failed");

`endif

@@ design/srsw_pkg.sv @@
`default_nettype none

package srsw_pkg;

  localparam int SEQ_W      = 8;
  localparam int OP_W       = 2;
  localparam int PC_W       = 9;
  localparam int WS_W       = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [OP_W-1:0] OP_START   = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_NACK    = 2'd2;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PKT_TOTAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LIMIT = 1'd1;

  localparam logic [PC_W-1:0] PKT_TOTAL_RST = 9'd5;
  localparam logic [WS_W-1:0] WIN_LIMIT_RST = 5'd2;

  // Transmissions ordered per input at most
  localparam int RES_LIMIT = 16;
  localparam int RES_CNT_W = 5;
  localparam int RES_IDX_W = 4;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [SEQ_W-1:0] seq;
  } in_item_t;

  typedef struct packed {
    logic             send_valid;
    logic [SEQ_W-1:0] send_seq;
    logic             last;
    logic             all_done;
    logic             ignored;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clr_state;
    logic set_ack;
    logic push_in;
    logic set_ign;
    logic tout_init;
    logic start_step;
    logic tout_step;
    logic slide_step;
    logic emit;
  } srsw_cmd_t;

  typedef struct packed {
    logic seq_oob;
    logic start_more;
    logic tout_more;
    logic slide_more;
    logic out_free;
    logic emit_last;
  } srsw_sts_t;

endpackage

`default_nettype wire

@@ design/srsw_ctrl.sv @@
`default_nettype none

module srsw_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [srsw_pkg::OP_W-1:0]         in_op,
  output logic                              in_stall,
  input  srsw_pkg::srsw_sts_t               sts,
  output srsw_pkg::srsw_cmd_t               cmd
);
  import srsw_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_TOUT  = 3'd2;
  localparam logic [2:0] S_SLIDE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_op)
            OP_START: begin
              cmd.clr_state = 1'b1;
              state_nxt     = S_START;
            end
            OP_TIMEOUT: begin
              cmd.tout_init = 1'b1;
              state_nxt     = S_TOUT;
            end
            OP_ACK: begin
              if (sts.seq_oob) begin
                cmd.set_ign = 1'b1;
                state_nxt   = S_EMIT;
              end else begin
                cmd.set_ack = 1'b1;
                state_nxt   = S_SLIDE;
              end
            end
            OP_NACK: begin
              if (sts.seq_oob) begin
                cmd.set_ign = 1'b1;
                state_nxt   = S_EMIT;
              end else begin
                cmd.push_in = 1'b1;
                state_nxt   = S_SLIDE;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_START: begin
        if (sts.start_more) cmd.start_step = 1'b1;
        else state_nxt = S_EMIT;
      end
      S_TOUT: begin
        if (sts.tout_more) cmd.tout_step = 1'b1;
        else state_nxt = S_EMIT;
      end
      S_SLIDE: begin
        if (sts.slide_more) cmd.slide_step = 1'b1;
        else state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/srsw_dpath.sv @@
`default_nettype none

module srsw_dpath #(
  parameter int MAX_PACKETS = 256,
  parameter int MAX_WINDOW  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [srsw_pkg::SEQ_W-1:0]        in_seq,
  input  srsw_pkg::srsw_cmd_t               cmd,
  output srsw_pkg::srsw_sts_t               sts,
  output logic                              out_valid,
  input  logic                              out_stall,
  output srsw_pkg::out_item_t               out_data
);
  import srsw_pkg::*;

  localparam int AW = $clog2(MAX_PACKETS);
  localparam int CW = $clog2(MAX_PACKETS + 1);
  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int XW = (CW > SEQ_W) ? CW : SEQ_W;
  localparam int YW = (CW > PC_W) ? CW : PC_W;
  localparam int ZW = (CW > WW) ? CW : WW;
  localparam int VW = (WW > WS_W) ? WW : WS_W;

  logic [PC_W-1:0]        pc_r;
  logic [WS_W-1:0]        ws_r;
  logic [MAX_PACKETS-1:0] acked_r;
  logic [CW-1:0]          base_r;
  logic [CW-1:0]          next_r;
  logic [CW-1:0]          ptr_r;
  logic [RES_CNT_W-1:0]   res_cnt_r;
  logic [RES_CNT_W-1:0]   res_cnt_nxt;
  logic [RES_IDX_W-1:0]   rd_r;
  logic                   ign_r;
  logic [SEQ_W-1:0]       buf_r [RES_LIMIT];
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic [CW-1:0]          cnt;
  logic [WW-1:0]          win;
  logic [XW-1:0]          seq_ext;
  logic [XW-1:0]          next_ext;
  logic [XW-1:0]          ptr_ext;
  logic [AW-1:0]          seq_idx;
  logic [AW-1:0]          base_idx;
  logic [AW-1:0]          ptr_idx;
  logic                   res_room;
  logic                   next_in_range;
  logic                   push_en;
  logic [SEQ_W-1:0]       push_val;
  logic [RES_CNT_W-1:0]   wr_base;
  logic [RES_IDX_W-1:0]   wr_idx;
  logic                   has_send;

  // Config values clamped to their legal ranges
  always_comb begin
    if (pc_r == '0) cnt = CW'(1);
    else if (YW'(pc_r) > YW'(MAX_PACKETS)) cnt = CW'(MAX_PACKETS);
    else cnt = CW'(pc_r);
    if (ws_r == '0) win = WW'(1);
    else if (VW'(ws_r) > VW'(MAX_WINDOW)) win = WW'(MAX_WINDOW);
    else win = WW'(ws_r);
  end

  assign seq_ext  = XW'(in_seq);
  assign next_ext = XW'(next_r);
  assign ptr_ext  = XW'(ptr_r);
  assign seq_idx  = seq_ext[AW-1:0];
  assign base_idx = base_r[AW-1:0];
  assign ptr_idx  = ptr_r[AW-1:0];

  assign res_room      = (res_cnt_r < RES_CNT_W'(RES_LIMIT));
  assign next_in_range = (next_r < cnt);

  assign sts.seq_oob    = (seq_ext >= XW'(cnt));
  assign sts.start_more = res_room && (ZW'(next_r) < ZW'(win)) && next_in_range;
  assign sts.tout_more  = res_room && (ptr_r < next_r);
  assign sts.slide_more = res_room && (base_r < cnt) && acked_r[base_idx];
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.emit_last  = (res_cnt_r == '0) ||
                          ((RES_CNT_W'(rd_r) + RES_CNT_W'(1)) == res_cnt_r);

  always_comb begin
    push_en  = 1'b0;
    push_val = next_ext[SEQ_W-1:0];
    if (cmd.push_in) begin
      push_en  = 1'b1;
      push_val = in_seq;
    end
    if (cmd.start_step) push_en = 1'b1;
    if (cmd.slide_step) push_en = next_in_range;
    if (cmd.tout_step) begin
      push_en  = !acked_r[ptr_idx];
      push_val = ptr_ext[SEQ_W-1:0];
    end
  end

  // A new item restarts the result list at entry zero
  assign wr_base     = cmd.load ? '0 : res_cnt_r;
  assign wr_idx      = wr_base[RES_IDX_W-1:0];
  assign res_cnt_nxt = wr_base + RES_CNT_W'(push_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PKT_TOTAL_RST;
      ws_r        <= WIN_LIMIT_RST;
      acked_r     <= '0;
      base_r      <= '0;
      next_r      <= '0;
      res_cnt_r   <= '0;
      rd_r        <= '0;
      ign_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PKT_TOTAL: pc_r <= cfg_data[PC_W-1:0];
          CFG_WIN_LIMIT: ws_r <= cfg_data[WS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_state) begin
        acked_r <= '0;
        base_r  <= '0;
        next_r  <= '0;
      end
      if (cmd.set_ack) acked_r[seq_idx] <= 1'b1;
      if (cmd.start_step) next_r <= next_r + CW'(1);
      if (cmd.slide_step) begin
        base_r <= base_r + CW'(1);
        if (next_in_range) next_r <= next_r + CW'(1);
      end
      res_cnt_r <= res_cnt_nxt;
      if (cmd.load) begin
        rd_r  <= '0;
        ign_r <= cmd.set_ign;
      end else if (cmd.emit) begin
        rd_r <= rd_r + RES_IDX_W'(1);
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign has_send = (res_cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push_en) buf_r[wr_idx] <= push_val;
    if (cmd.tout_init) ptr_r <= base_r;
    else if (cmd.tout_step) ptr_r <= ptr_r + CW'(1);
    if (cmd.emit) begin
      out_data_r.send_valid <= has_send;
      out_data_r.send_seq   <= has_send ? buf_r[rd_r] : '0;
      out_data_r.last       <= sts.emit_last;
      out_data_r.all_done   <= (base_r >= cnt);
      out_data_r.ignored    <= ign_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ design/selective_repeat_sender_window.sv @@
// Selective-repeat ARQ sender window.
// Input channel (in_valid/in_stall/in_data): one event per transfer, an
// operation (start, ack, nack, timeout) and the seq it carries.
// Result channel (out_valid/out_stall/out_data): one transfer per ordered
// packet transmission; an event that orders nothing gives a single result
// with send_valid low. The final result of each event has last set.
// Config port: cfg_we writes the packet total (index 0) or the window
// limit (index 1); write only while no event is in progress.
// Operation: an event is taken when idle, then walks one entry per cycle
// (start: up to window entries; timeout: the span base..next; slide: each
// acknowledged entry at the base), with at most 16 transmissions collected.
// Results then leave one per cycle from an output register, unless the
// receiver stalls; in_stall stays high while an event is in progress.
// A stalled result holds in the output register and pauses the walk out;
// the next event is taken while the final result still waits.
// Reset (rst_n low, synchronous) clears the acknowledged map, base and next
// sequence and loads a packet total of 5 and a window limit of 2.
`default_nettype none

module selective_repeat_sender_window #(
  parameter int MAX_PACKETS = 256,
  parameter int MAX_WINDOW  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  srsw_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output srsw_pkg::out_item_t               out_data
);
  import srsw_pkg::*;

  srsw_cmd_t cmd;
  srsw_sts_t sts;

  srsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  srsw_dpath #(
    .MAX_PACKETS (MAX_PACKETS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_seq    (in_data.seq),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ design/srsw_checker.sv @@
`default_nettype none
`include "selective_repeat_sender_window_assert.svh"

module srsw_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input srsw_pkg::out_item_t  out_data
);
  import srsw_pkg::*;

  // stalled result holds
  `SRSW_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // a result that orders nothing is always the only one of its event
  `SRSW_ASSERT_IMP(a_empty_last, out_valid && !out_data.send_valid, out_data.last)
  // an out-of-range seq orders no transmission
  `SRSW_ASSERT_IMP(a_ign_nosend, out_valid && out_data.ignored, !out_data.send_valid && out_data.last)
  // one event in progress at a time
  `SRSW_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall)

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

@@ verif/selective_repeat_sender_window_checker.sv @@
module selective_repeat_sender_window_checker #(
  parameter int MAX_PACKETS = 256,
  parameter int MAX_WINDOW  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  srsw_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  srsw_pkg::out_item_t             out_data,
  output int                              fail_count,
  output int                              pending
);
  import srsw_pkg::*;

  logic [PC_W-1:0]        pkt_total;
  logic [WS_W-1:0]        win_limit;
  bit   [MAX_PACKETS-1:0] acked;
  int                     base;
  int                     next_seq;
  out_item_t              send_q[$];
  int                     errors = 0;

  function automatic out_item_t tx_order(int s);
    out_item_t r;
    r = '0;
    r.send_valid = 1'b1;
    r.send_seq = s[SEQ_W-1:0];
    return r;
  endfunction

  // Works out the transmissions one event orders and queues them in order.
  task automatic predict_sends(in_item_t ev);
    out_item_t res[$];
    out_item_t r;
    int        cnt;
    int        win;
    int        i;
    bit        ign;
    ign = 1'b0;
    cnt = pkt_total;
    if (cnt < 1) cnt = 1;
    if (cnt > MAX_PACKETS) cnt = MAX_PACKETS;
    win = win_limit;
    if (win < 1) win = 1;
    if (win > MAX_WINDOW) win = MAX_WINDOW;
    case (ev.operation)
      OP_START: begin
        acked = '0;
        base = 0;
        next_seq = 0;
        while (res.size() < RES_LIMIT && next_seq < base + win && next_seq < cnt) begin
          res.push_back(tx_order(next_seq));
          next_seq++;
        end
      end
      OP_TIMEOUT: begin
        for (i = base; i < next_seq && i < MAX_PACKETS && res.size() < RES_LIMIT; i++) begin
          if (!acked[i]) res.push_back(tx_order(i));
        end
      end
      default: begin
        if (ev.seq >= cnt) begin
          ign = 1'b1;
        end else begin
          if (ev.operation == OP_ACK) acked[ev.seq] = 1'b1;
          else res.push_back(tx_order(ev.seq));
          // slide stops once the per-event budget is spent
          while (res.size() < RES_LIMIT && base < cnt && acked[base]) begin
            base++;
            if (next_seq < cnt) begin
              res.push_back(tx_order(next_seq));
              next_seq++;
            end
          end
        end
      end
    endcase
    if (res.size() == 0) res.push_back(out_item_t'('0));
    foreach (res[j]) begin
      r = res[j];
      r.last = (j == res.size() - 1);
      r.all_done = (base >= cnt);
      r.ignored = ign;
      send_q.push_back(r);
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      pkt_total = PKT_TOTAL_RST;
      win_limit = WIN_LIMIT_RST;
      acked = '0;
      base = 0;
      next_seq = 0;
      send_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PKT_TOTAL) pkt_total = cfg_data[PC_W-1:0];
        else if (cfg_index == CFG_WIN_LIMIT) win_limit = cfg_data[WS_W-1:0];
      end
      // results first: a result never belongs to an event taken at the same edge
      if (out_valid && !out_stall) begin
        if (send_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual send_valid %0d send_seq %0d",
                   $time, out_data.send_valid, out_data.send_seq);
        end else begin
          want = send_q.pop_front();
          check_field("send_valid", want.send_valid, out_data.send_valid);
          check_field("send_seq", want.send_seq, out_data.send_seq);
          check_field("last", want.last, out_data.last);
          check_field("all_done", want.all_done, out_data.all_done);
          check_field("ignored", want.ignored, out_data.ignored);
        end
      end
      if (in_valid && !in_stall) predict_sends(in_data);
    end
    fail_count <= errors;
    pending <= send_q.size();
  end

endmodule

@@ verif/selective_repeat_sender_window_tb.sv @@
module selective_repeat_sender_window_tb;
  import srsw_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PKT_TOTAL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  int                    fail_count;
  int                    pending;
  bit                    sender_idle = 1'b1;
  bit                    sink_idle = 1'b1;
  int                    stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  selective_repeat_sender_window u_top (.*);

  selective_repeat_sender_window_checker u_check (.*);

  // Receiver back-pressure in random bursts while sink_idle is set.
  always @(posedge clk) begin
    if (sink_idle && stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (sink_idle && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_event(logic [OP_W-1:0] op, logic [SEQ_W-1:0] seq);
    in_item_t ev;
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    ev.operation = op;
    ev.seq = seq;
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic configure(int count, int win);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PKT_TOTAL;
    cfg_data <= count[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_WIN_LIMIT;
    cfg_data <= win[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One transfer: a start, then an ack for each of the first n_acks packets,
  // partly out of order, with nacks, timeouts and stray events mixed in.
  task automatic run_transfer(int n_acks, int seq_span);
    int ack_order[$];
    int i;
    int j;
    int len;
    int pick;
    for (i = 0; i < n_acks; i++) ack_order.push_back(i);
    // reversed runs longer than the result budget make the slide stop early
    i = 0;
    while (i < n_acks) begin
      len = $urandom_range(1, 20);
      if (len > n_acks - i) len = n_acks - i;
      if ($urandom_range(0, 2) == 0) begin
        for (j = 0; j < len / 2; j++) begin
          pick = ack_order[i + j];
          ack_order[i + j] = ack_order[i + len - 1 - j];
          ack_order[i + len - 1 - j] = pick;
        end
      end
      i += len;
    end
    send_event(OP_START, SEQ_W'($urandom_range(0, 255)));
    foreach (ack_order[k]) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) send_event(OP_NACK, SEQ_W'($urandom_range(0, seq_span)));
      else if (pick < 5) send_event(OP_TIMEOUT, SEQ_W'($urandom_range(0, 255)));
      else if (pick == 5) send_event(OP_W'($urandom_range(OP_ACK, OP_TIMEOUT)),
                                     SEQ_W'($urandom_range(0, 255)));
      send_event(OP_ACK, SEQ_W'(ack_order[k]));
    end
  endtask

  initial begin
    int pc;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: five packets, window of two
    send_event(OP_START, 8'hA5);
    send_event(OP_ACK, 8'd0);
    send_event(OP_ACK, 8'd2);
    send_event(OP_NACK, 8'd1);
    send_event(OP_TIMEOUT, 8'd0);
    send_event(OP_ACK, 8'd1);
    send_event(OP_ACK, 8'd5);
    send_event(OP_NACK, 8'hFF);
    send_event(OP_ACK, 8'd3);
    send_event(OP_ACK, 8'd4);
    send_event(OP_TIMEOUT, 8'hFF);
    send_event(OP_ACK, 8'd4);

    // zero in both registers clamps to one
    wait_drained();
    configure(0, 0);
    send_event(OP_START, 8'd0);
    send_event(OP_NACK, 8'd0);
    send_event(OP_ACK, 8'd0);
    send_event(OP_ACK, 8'd1);

    // all ones clamps to the maximum packet count and window
    wait_drained();
    configure(9'h1FF, 5'h1F);
    send_event(OP_START, 8'h5A);
    send_event(OP_TIMEOUT, 8'd0);
    send_event(OP_NACK, 8'hFF);
    send_event(OP_ACK, 8'h80);

    wait_drained();
    pc = $urandom_range(6, 20);
    configure(pc, $urandom_range(1, 8));
    run_transfer(pc, pc + 2);

    wait_drained();
    configure(256, 16);
    run_transfer(24, 40);

    wait_drained();
    sender_idle = 1'b0;
    sink_idle <= 1'b0;
    configure($urandom_range(257, 511), $urandom_range(17, 31));
    run_transfer(20, 255);

    wait_drained();
    sender_idle = 1'b1;
    sink_idle <= 1'b1;
    pc = $urandom_range(1, 12);
    configure(pc, $urandom_range(0, 3));
    run_transfer(pc, pc + 2);

    // closing transfer at full rate
    wait_drained();
    sender_idle = 1'b0;
    sink_idle <= 1'b0;
    pc = $urandom_range(2, 30);
    configure(pc, $urandom_range(1, 16));
    run_transfer(pc, pc + 2);

    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
